[sv/brg_pkg.sv]
// ----------------------------------------------------------------------------
// brg_pkg
// Shared types, register codes and helpers for the bit width regrouper.
// ----------------------------------------------------------------------------
`default_nettype none

package brg_pkg;

  // Configuration register indexes.
  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_OUT_WIDTH = 1'b1;

  // Widths of the datapath.
  localparam int unsigned WORD_W = 8;
  localparam int unsigned ACC_W  = 15;
  localparam int unsigned CFG_W  = 4;

  // Fields of one input item.
  typedef struct packed {
    logic [WORD_W-1:0] in_word;
    logic              in_last;
  } brg_in_t;

  // Fields of one result item.
  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              out_last;
    logic              out_partial;
  } brg_out_t;

  // Mask with the low n bits set, for n from 0 to 8.
  function automatic logic [WORD_W-1:0] low_mask8(input logic [CFG_W-1:0] n);
    logic [WORD_W:0] m;
    m = ({{WORD_W{1'b0}}, 1'b1} << n) - {{WORD_W{1'b0}}, 1'b1};
    return m[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/brg_shift_unit.sv]
// ----------------------------------------------------------------------------
// brg_shift_unit
// Shared extract-and-shift unit: takes the low group of bits off the
// accumulator and returns the accumulator shifted right by the group width.
// ----------------------------------------------------------------------------
`default_nettype none

module brg_shift_unit (
  input  wire logic [brg_pkg::ACC_W-1:0]  acc,
  input  wire logic [brg_pkg::CFG_W-1:0]  amt,
  output logic      [brg_pkg::WORD_W-1:0] group,
  output logic      [brg_pkg::ACC_W-1:0]  rest
);
  import brg_pkg::*;

  // The group is the low amt bits; the rest moves down by amt.
  always_comb begin
    group = acc[WORD_W-1:0] & low_mask8(amt);
    rest  = acc >> amt;
  end

endmodule

`default_nettype wire

[sv/bit_width_regrouper_top.sv]
// ----------------------------------------------------------------------------
// bit_width_regrouper_top
// LSB-first bit width gearbox. Input symbols of in_width bits are gathered
// in an accumulator and sent out again in groups of out_width bits; an item
// marked last flushes the leftover bits as one zero-padded word.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data  (brg_in_t)
//   out      output     out_valid / out_stall out_data (brg_out_t)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// An item is first merged into the accumulator; then the 1 to 8 words that it
// causes, if any, are taken off one after another through the single shift
// unit. The output register holds one word, so a stall on the out channel
// holds the sequencer. in_stall is high from the cycle after an accept until
// the last word of that item is loaded. Reset clears the accumulator and the
// held-bit count and sets both widths to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_width_regrouper_top #(
  parameter int MAX_SYMBOL_WIDTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire brg_pkg::brg_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output brg_pkg::brg_out_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [brg_pkg::CFG_W-1:0]  cfg_data
);
  import brg_pkg::*;

  localparam int CAP_I = (MAX_SYMBOL_WIDTH < 8) ? MAX_SYMBOL_WIDTH : 8;
  localparam logic [CFG_W-1:0] CAP = CFG_W'(CAP_I);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  in_width;
  logic [CFG_W-1:0]  out_width;
  logic [ACC_W-1:0]  acc;
  logic [CFG_W-1:0]  held;
  logic [CFG_W-1:0]  count;
  logic              last_item;

  logic [CFG_W-1:0]  iw;
  logic [CFG_W-1:0]  ow;
  logic [WORD_W-1:0] in_bits;
  logic [WORD_W-1:0] group;
  logic [ACC_W-1:0]  rest;
  logic [CFG_W-1:0]  held_next;
  logic [CFG_W-1:0]  count_next;
  logic              full_word;
  logic              flush_word;
  logic              more;
  logic              can_load;
  logic              load_word;
  logic              accept;

  // Effective widths: zero acts as one, large values are capped.
  always_comb begin
    if (in_width == '0) begin
      iw = 4'd1;
    end else if (in_width > CAP) begin
      iw = CAP;
    end else begin
      iw = in_width;
    end
    if (out_width == '0) begin
      ow = 4'd1;
    end else if (out_width > CAP) begin
      ow = CAP;
    end else begin
      ow = out_width;
    end
  end

  brg_shift_unit u_shift (
    .acc   (acc),
    .amt   (ow),
    .group (group),
    .rest  (rest)
  );

  // Sequencer decisions for the current emit cycle.
  always_comb begin
    in_bits    = in_data.in_word & low_mask8(iw);
    accept     = in_valid && !in_stall;
    can_load   = !out_valid || !out_stall;
    full_word  = (held >= ow) && !count[CFG_W-1];
    flush_word = last_item && (held != '0) && !count[CFG_W-1];
    held_next  = held - ow;
    count_next = count + 4'd1;
    more       = !count_next[CFG_W-1] &&
                 ((held_next >= ow) || (last_item && (held_next != '0)));
    load_word  = (state == ST_EMIT) && can_load && (full_word || flush_word);
    in_stall   = (state != ST_IDLE);
  end

  // State, accumulator, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_width  <= 4'd8;
      out_width <= 4'd8;
      acc       <= '0;
      held      <= '0;
      count     <= '0;
      last_item <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IN_WIDTH:  in_width  <= cfg_data;
          REG_OUT_WIDTH: out_width <= cfg_data;
          default:       ;
        endcase
      end

      // The output register empties when its word is taken and no new one
      // replaces it.
      if (out_valid && !out_stall && !load_word) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            acc       <= acc | (ACC_W'(in_bits) << held);
            held      <= held + iw;
            count     <= '0;
            last_item <= in_data.in_last;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_load) begin
            if (full_word) begin
              out_valid            <= 1'b1;
              out_data.out_word    <= group;
              out_data.out_last    <= last_item && !more;
              out_data.out_partial <= 1'b0;
              acc                  <= (!more && last_item) ? '0 : rest;
              held                 <= (!more && last_item) ? '0 : held_next;
              count                <= count_next;
              if (!more) begin
                state <= ST_IDLE;
              end
            end else if (flush_word) begin
              out_valid            <= 1'b1;
              out_data.out_word    <= acc[WORD_W-1:0];
              out_data.out_last    <= 1'b1;
              out_data.out_partial <= 1'b1;
              acc                  <= '0;
              held                 <= '0;
              state                <= ST_IDLE;
            end else begin
              // No word at all for this item.
              state <= ST_IDLE;
              if (last_item) begin
                acc  <= '0;
                held <= '0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/brg_checker.sv]
// ----------------------------------------------------------------------------
// brg_checker
// Port-level checks on the bit width regrouper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brg_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire brg_pkg::brg_out_t          out_data
);

  // A word held back by the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // A flush word always closes the item.
  a_partial_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.out_partial || out_data.out_last))
    else $error("partial word without last mark");

  // One item at a time: the block is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bit_width_regrouper_top brg_checker u_brg_checker (.*);

`default_nettype wire

[test/bit_width_regrouper_top_tb.sv]
// ----------------------------------------------------------------------------
// bit_width_regrouper_top_tb
// Self-checking bench for the LSB-first bit width gearbox. A scoreboard keeps
// its own copy of the accumulator and the two widths, and it predicts every
// output word from the input items that the block accepts. A short directed
// part covers extreme widths, out-of-range register values, the zero-padded
// flush, the eight-word limit and a width change mid-stream. Random streams
// with random width settings follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module bit_width_regrouper_top_tb;
  import brg_pkg::*;

  localparam int unsigned SYM_MAX      = 8;
  localparam int unsigned MAX_WORDS    = 8;
  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned QUIET_LIMIT  = 2000;

  // Predicts the words that each accepted input item causes and checks the
  // words that come out against them, oldest first.
  class regroup_scoreboard;
    logic [CFG_W-1:0] in_sel;
    logic [CFG_W-1:0] out_sel;
    logic [ACC_W-1:0] acc;
    int unsigned      held;
    brg_out_t         expected_words[$];
    int unsigned      errors;
    int unsigned      items_in;
    int unsigned      words_out;
    int unsigned      flushes;
    int unsigned      stream_ends;

    function new();
      in_sel      = 4'd8;
      out_sel     = 4'd8;
      acc         = '0;
      held        = 0;
      errors      = 0;
      items_in    = 0;
      words_out   = 0;
      flushes     = 0;
      stream_ends = 0;
    endfunction

    // A register value of zero acts as one; values above the cap act as the cap.
    function int unsigned effective(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SYM_MAX) return SYM_MAX;
      return v;
    endfunction

    function logic [ACC_W-1:0] ones(int unsigned n);
      logic [31:0] m;
      m = (32'd1 << n) - 32'd1;
      return m[ACC_W-1:0];
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_IN_WIDTH) begin
        in_sel = val;
      end else begin
        out_sel = val;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // Append one word at the tail of the expected list.
    function void add_word(brg_out_t w);
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void note_input(brg_in_t item);
      int unsigned      iw;
      int unsigned      ow;
      int unsigned      n;
      logic [ACC_W-1:0] fresh;
      logic [ACC_W-1:0] picked;
      brg_out_t         w;
      iw = effective(in_sel);
      ow = effective(out_sel);
      items_in++;

      // Merge the new bits above the ones already held.
      fresh = '0;
      fresh[WORD_W-1:0] = item.in_word;
      fresh = fresh & ones(iw);
      acc = acc | (fresh << held);
      held = held + iw;

      // Emit full words while enough bits are held, at most eight per item.
      n = 0;
      while (held >= ow && n < MAX_WORDS) begin
        picked = acc & ones(ow);
        w.out_word    = picked[WORD_W-1:0];
        w.out_last    = 1'b0;
        w.out_partial = 1'b0;
        add_word(w);
        acc = acc >> ow;
        held = held - ow;
        n++;
      end

      // End of stream: flush leftovers and mark the final word of this item.
      if (item.in_last) begin
        if (held > 0 && n < MAX_WORDS) begin
          picked = acc & ones(held);
          w.out_word    = picked[WORD_W-1:0];
          w.out_last    = 1'b0;
          w.out_partial = 1'b1;
          add_word(w);
          flushes++;
          n++;
        end
        if (n > 0) begin
          // w still holds the word that was added last.
          w.out_last = 1'b1;
          expected_words[expected_words.size() - 1] = w;
          stream_ends++;
        end
        acc = '0;
        held = 0;
      end
      held = held & 15;
    endfunction

    function void check_result(brg_out_t got);
      brg_out_t want;
      words_out++;
      if (expected_words.size() == 0) begin
        errors++;
        $error("unexpected output word %0h (last %0b, partial %0b)",
               got.out_word, got.out_last, got.out_partial);
        return;
      end
      want = expected_words.pop_front();
      if (got.out_word !== want.out_word) begin
        errors++;
        $error("out_word: expected %0h, got %0h", want.out_word, got.out_word);
      end
      if (got.out_last !== want.out_last) begin
        errors++;
        $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
      end
      if (got.out_partial !== want.out_partial) begin
        errors++;
        $error("out_partial: expected %0b, got %0b", want.out_partial, got.out_partial);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  brg_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  brg_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;

  regroup_scoreboard board;
  bit                tx_idle = 1'b0;
  bit                rx_idle = 1'b0;
  int unsigned       quiet   = 0;
  int unsigned       settings_used = 0;
  int unsigned       sent;
  int unsigned       k;
  int unsigned       phase_len;
  int unsigned       stream_left;
  logic              end_of_stream;

  bit_width_regrouper_top #(
    .MAX_SYMBOL_WIDTH(SYM_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [WORD_W-1:0] word, input logic last);
    brg_in_t item;
    item.in_word = word;
    item.in_last = last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(item);
  endtask

  // Drain every expected word, then leave room for an item that makes none.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both width registers, the in width first and then the out width.
  task automatic set_widths(input logic [CFG_W-1:0] iw, input logic [CFG_W-1:0] ow);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IN_WIDTH;
    cfg_data  <= iw;
    @(posedge clk);
    board.write_reg(REG_IN_WIDTH, iw);
    cfg_index <= REG_OUT_WIDTH;
    cfg_data  <= ow;
    @(posedge clk);
    board.write_reg(REG_OUT_WIDTH, ow);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Extremes often, any 4-bit value otherwise.
  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 3))
      0: return 4'd1;
      1: return 4'd8;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // Output side stalls in random bursts while enabled.
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check accepted words and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("bit_width_regrouper_top test failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset widths: two bytes, the second ends the stream with nothing left.
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    settle();

    // Odd ratio: one full word, then a padded flush of the leftover bits.
    set_widths(4'd3, 4'd5);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h01, 1'b1);
    settle();

    // One byte spread into eight single bits.
    set_widths(4'd8, 4'd1);
    send_item(8'hA5, 1'b1);
    settle();

    // Zero and oversized register values act as one and eight.
    set_widths(4'd0, 4'd15);
    send_item(8'h01, 1'b1);
    send_item(8'hFE, 1'b1);
    settle();
    set_widths(4'd9, 4'd0);
    send_item(8'h3C, 1'b1);
    settle();

    // Bits held across a width change; the next items hit the eight-word cap.
    set_widths(4'd7, 4'd8);
    send_item(8'h7F, 1'b0);
    settle();
    set_widths(4'd8, 4'd1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    settle();
    set_widths(4'd8, 4'd7);
    send_item(8'h80, 1'b0);
    send_item(8'h55, 1'b1);

    // Random streams under random widths; phases may cut a stream short.
    sent = 0;
    stream_left = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      set_widths(pick_width(), pick_width());
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 50);
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        if (sent + 60 >= RANDOM_ITEMS) begin
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        if (tx_idle && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        if (stream_left == 0) stream_left = $urandom_range(1, 12);
        end_of_stream = (stream_left == 1) || ($urandom_range(0, 24) == 0);
        stream_left = end_of_stream ? 0 : stream_left - 1;
        send_item(8'($urandom_range(0, 255)), end_of_stream);
        sent++;
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("Sent %0d items under %0d width settings; checked %0d words.",
             board.items_in, settings_used, board.words_out);
    $display("Saw %0d stream ends and %0d zero-padded flush words.",
             board.stream_ends, board.flushes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("bit_width_regrouper_top test passed");
    end else begin
      $display("bit_width_regrouper_top test failed");
    end
    $finish;
  end

endmodule
